@@ src/wcjh_pkg.sv @@
// Shared types and constants of the wind class joint histogram.
package wcjh_pkg;

    // Fixed field widths
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int KEY_W     = MONTH_W + DAY_W;
    localparam int SPEED_W   = 16;
    localparam int CLASS_W   = 3;
    localparam int DIR_W     = 5;
    localparam int BIN_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int OUT_W     = 20;
    localparam int SHARE_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 5;

    // Speed class thresholds in cm/s
    localparam int EDGE_COUNT = 7;
    localparam logic [SPEED_W-1:0] SPEED_EDGES [EDGE_COUNT] = '{
        16'd75, 16'd150, 16'd250, 16'd350, 16'd550, 16'd750, 16'd1000
    };

    // Warm window defaults: 16 April to 15 October
    localparam logic [MONTH_W-1:0] RST_START_MONTH = 4'd4;
    localparam logic [DAY_W-1:0]   RST_START_DAY   = 5'd15;
    localparam logic [MONTH_W-1:0] RST_END_MONTH   = 4'd10;
    localparam logic [DAY_W-1:0]   RST_END_DAY     = 5'd15;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARM_START_MONTH,
        REG_WARM_START_DAY,
        REG_WARM_END_MONTH,
        REG_WARM_END_DAY
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BAD_CLASS,
        ST_NEG_SPEED,
        ST_BAD_DIR,
        ST_BAD_READ
    } status_t;

endpackage

@@ src/wcjh_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module wcjh_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1792
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/wcjh_div.sv @@
// Restoring divider giving floor(num * 2^16 / den) one quotient bit per cycle.
module wcjh_div
    import wcjh_pkg::*;
#(
    parameter int W = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [W-1:0]       num,
    input  logic [W-1:0]       den,
    output logic               done,
    output logic [SHARE_W-1:0] quotient
);

    localparam int CW = $clog2(SHARE_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(SHARE_W - 1);

    logic [W:0]         rem_reg;
    logic [W-1:0]       den_reg;
    logic [SHARE_W-1:0] q_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               zero_reg;
    logic               done_reg;
    logic [W+1:0]       diff;
    logic               fits;

    // Trial subtraction; num <= den keeps the quotient within 17 bits
    assign diff = {1'b0, rem_reg} - {2'b00, den_reg};
    assign fits = ~diff[W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            zero_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                zero_reg <= (den == '0);
            end
            else if (busy_reg)
            begin
                q_reg   <= {q_reg[SHARE_W-2:0], fits};
                rem_reg <= fits ? {diff[W-1:0], 1'b0} : {rem_reg[W-1:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : q_reg;

endmodule

@@ src/wind_class_joint_histogram.sv @@
// Top level of the wind class joint histogram: sequencer, counters and cell store.
//
// Counts weather observations in a joint histogram over season (warm/cold by a
// configurable date window), wind direction, stability class and speed bin, and
// answers reads of one cell with its count and Q1.16 share of the season total.
// After reset the cell store is swept to zero, one entry a cycle, over all
// 2*DIRECTIONS*CLASSES*SPEED_BINS entries (1792 with the defaults); no item is
// taken meanwhile, configuration writes are. A valid item then passes through
// a store read, a read-modify-write of the cell and the totals, and the
// bit-serial divider that forms the share. A rejected item goes from acceptance
// straight to the done state and gives its status from there. Only one
// item is in work at a time; a finished result waits in the output register
// while the next item is taken.
module wind_class_joint_histogram
    import wcjh_pkg::*;
#(
    parameter int DIRECTIONS = 16,
    parameter int CLASSES    = 7,
    parameter int SPEED_BINS = 8,
    parameter int COUNT_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [CLASS_W-1:0]   stability_class,
    input  logic signed [SPEED_W-1:0] wind_speed,
    input  logic [DIR_W-1:0]     wind_dir,
    input  logic [MONTH_W-1:0]   obs_month,
    input  logic [DAY_W-1:0]     obs_day,
    input  logic                 read_season,
    input  logic [BIN_W-1:0]     read_speed_bin,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [OUT_W-1:0]     cell_count,
    output logic [SHARE_W-1:0]   cell_share,
    output logic [OUT_W-1:0]     season_total,
    output logic [OUT_W-1:0]     season_wind_total
);

    localparam int DEPTH = 2 * DIRECTIONS * CLASSES * SPEED_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIVIDE,
        S_DONE
    } state_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Registers
    state_t                state_reg;
    logic [AW-1:0]         clr_reg;
    logic [MONTH_W-1:0]    start_month_reg;
    logic [DAY_W-1:0]      start_day_reg;
    logic [MONTH_W-1:0]    end_month_reg;
    logic [DAY_W-1:0]      end_day_reg;
    logic                  req_reg;
    logic                  season_reg;
    logic [AW-1:0]         addr_reg;
    logic [BIN_W-1:0]      bin_reg;
    logic [COUNT_BITS-1:0] tot_reg  [2];
    logic [COUNT_BITS-1:0] wtot_reg [2];
    status_t               res_status_reg;
    logic [COUNT_BITS-1:0] res_count_reg;
    logic [SHARE_W-1:0]    res_share_reg;
    logic [COUNT_BITS-1:0] res_tot_reg;
    logic [COUNT_BITS-1:0] res_wtot_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic [SHARE_W-1:0]    out_share_reg;
    logic [COUNT_BITS-1:0] out_tot_reg;
    logic [COUNT_BITS-1:0] out_wtot_reg;

    // Combinational
    logic                  accept;
    logic                  out_take;
    logic                  out_load;
    logic                  cls_bad;
    logic                  dir_bad;
    logic                  bin_bad;
    logic                  speed_neg;
    status_t               in_status;
    logic [BIN_W-1:0]      raw_bin;
    logic [BIN_W-1:0]      obs_bin;
    logic [BIN_W-1:0]      cell_bin;
    logic [KEY_W-1:0]      obs_key;
    logic [KEY_W-1:0]      start_key;
    logic [KEY_W-1:0]      end_key;
    logic                  obs_warm;
    logic                  cell_season;
    logic [DIR_W-1:0]      dir_idx;
    logic [AW-1:0]         cell_addr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] upd_total;
    logic [COUNT_BITS-1:0] upd_wtotal;
    logic                  div_start;
    logic                  div_done;
    logic [SHARE_W-1:0]    div_q;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Request checks
    assign cls_bad   = {1'b0, stability_class} >= (CLASS_W + 1)'(CLASSES);
    assign dir_bad   = {1'b0, wind_dir} > (DIR_W + 1)'(DIRECTIONS);
    assign bin_bad   = {1'b0, read_speed_bin} >= (BIN_W + 1)'(SPEED_BINS);
    assign speed_neg = wind_speed[SPEED_W-1];

    always_comb
    begin
        if (req_type)
        begin
            in_status = (cls_bad || dir_bad || bin_bad) ? ST_BAD_READ : ST_OK;
        end
        else if (cls_bad)
        begin
            in_status = ST_BAD_CLASS;
        end
        else if (speed_neg)
        begin
            in_status = ST_NEG_SPEED;
        end
        else if (dir_bad)
        begin
            in_status = ST_BAD_DIR;
        end
        else
        begin
            in_status = ST_OK;
        end
    end

    // Speed bin: number of thresholds reached, capped at the top bin
    always_comb
    begin
        raw_bin = '0;
        for (int i = 0; i < EDGE_COUNT; i++)
        begin
            raw_bin = raw_bin + BIN_W'($unsigned(wind_speed) >= SPEED_EDGES[i]);
        end
        obs_bin = (raw_bin > BIN_W'(SPEED_BINS - 1)) ? BIN_W'(SPEED_BINS - 1) : raw_bin;
    end

    // Season window, dates keyed as month*32+day
    assign obs_key   = {obs_month, obs_day};
    assign start_key = {start_month_reg, start_day_reg};
    assign end_key   = {end_month_reg, end_day_reg};

    always_comb
    begin
        if (start_key < end_key)
        begin
            obs_warm = (obs_key > start_key) && (obs_key <= end_key);
        end
        else if (start_key > end_key)
        begin
            obs_warm = (obs_key > start_key) || (obs_key <= end_key);
        end
        else
        begin
            obs_warm = 1'b0;
        end
    end

    // Cell address; calm shares direction index 0 with north
    assign cell_season = req_type ? read_season : obs_warm;
    assign cell_bin    = req_type ? read_speed_bin : obs_bin;
    assign dir_idx     = (wind_dir == '0) ? '0 : wind_dir - 1'b1;
    assign cell_addr   = ((((AW'(cell_season) * AW'(DIRECTIONS)) + AW'(dir_idx))
                          * AW'(CLASSES) + AW'(stability_class))
                          * AW'(SPEED_BINS)) + AW'(cell_bin);

    // Read-modify-write values
    assign count_next = req_reg ? ram_rdata : sat_inc(ram_rdata);
    assign upd_total  = req_reg ? tot_reg[season_reg] : sat_inc(tot_reg[season_reg]);
    assign upd_wtotal = (!req_reg && (bin_reg != '0)) ? sat_inc(wtot_reg[season_reg])
                                                       : wtot_reg[season_reg];

    // Store write port: clearing sweep or cell update
    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_UPDATE) && !req_reg);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : count_next;
    assign div_start = (state_reg == S_UPDATE);

    wcjh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    wcjh_div #(
        .W (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (count_next),
        .den      (upd_total),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            start_month_reg <= RST_START_MONTH;
            start_day_reg   <= RST_START_DAY;
            end_month_reg   <= RST_END_MONTH;
            end_day_reg     <= RST_END_DAY;
            req_reg         <= 1'b0;
            season_reg      <= 1'b0;
            addr_reg        <= '0;
            bin_reg         <= '0;
            tot_reg[0]      <= '0;
            tot_reg[1]      <= '0;
            wtot_reg[0]     <= '0;
            wtot_reg[1]     <= '0;
            res_status_reg  <= ST_OK;
            res_count_reg   <= '0;
            res_share_reg   <= '0;
            res_tot_reg     <= '0;
            res_wtot_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_count_reg   <= '0;
            out_share_reg   <= '0;
            out_tot_reg     <= '0;
            out_wtot_reg    <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_WARM_START_MONTH: start_month_reg <= cfg_data[MONTH_W-1:0];
                    REG_WARM_START_DAY:   start_day_reg   <= cfg_data[DAY_W-1:0];
                    REG_WARM_END_MONTH:   end_month_reg   <= cfg_data[MONTH_W-1:0];
                    REG_WARM_END_DAY:     end_day_reg     <= cfg_data[DAY_W-1:0];
                    default:              start_month_reg <= start_month_reg;
                endcase
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_ADDR)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg        <= req_type;
                        season_reg     <= cell_season;
                        addr_reg       <= cell_addr;
                        bin_reg        <= cell_bin;
                        res_status_reg <= in_status;
                        if (in_status != ST_OK)
                        begin
                            res_count_reg <= '0;
                            res_share_reg <= '0;
                            res_tot_reg   <= '0;
                            res_wtot_reg  <= '0;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    res_count_reg        <= count_next;
                    res_tot_reg          <= upd_total;
                    res_wtot_reg         <= upd_wtotal;
                    tot_reg[season_reg]  <= upd_total;
                    wtot_reg[season_reg] <= upd_wtotal;
                    state_reg            <= S_DIVIDE;
                end
                S_DIVIDE:
                begin
                    if (div_done)
                    begin
                        res_share_reg <= div_q;
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // output register
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status_reg;
                out_count_reg  <= res_count_reg;
                out_share_reg  <= res_share_reg;
                out_tot_reg    <= res_tot_reg;
                out_wtot_reg   <= res_wtot_reg;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign cell_count        = OUT_W'(out_count_reg);
    assign cell_share        = out_share_reg;
    assign season_total      = OUT_W'(out_tot_reg);
    assign season_wind_total = OUT_W'(out_wtot_reg);

    // A cell never holds more than its season total
    a_count_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> (count_next <= upd_total))
        else $error("cell count exceeds season total");

    // The store is only written by the sweep or the update step
    a_no_write_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE || state_reg == S_DONE || state_reg == S_IDLE) |-> !ram_we)
        else $error("unexpected store write");

    // Divider finishes only while the sequencer waits on it
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVIDE))
        else $error("divider result outside divide step");

    // Share never above one
    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_q <= SHARE_W'(65536)))
        else $error("share above one");

    // An accepted item closes the input until its result is out
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("input open while item in work");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the wind class joint histogram, with its own histogram predictor.
module tb_top;
    import wcjh_pkg::*;

    localparam int DIRECTIONS     = 16;
    localparam int CLASSES        = 7;
    localparam int SPEED_BINS     = 8;
    localparam int COUNT_BITS     = 20;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int WINDOW_SETUPS  = 6;
    localparam int SETTLE_CYCLES  = 40;
    // store clearing after reset sweeps all 1792 entries, so allow for that several times over
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int RECENT_CELLS   = 64;
    localparam int DIR_MAX        = (1 << DIR_W) - 1;
    localparam int CLASS_MAX      = (1 << CLASS_W) - 1;

    localparam logic REQ_ADD     = 1'b0;
    localparam logic REQ_READ    = 1'b1;
    localparam logic SEASON_COLD = 1'b0;
    localparam logic SEASON_WARM = 1'b1;

    // one request item
    typedef struct packed {
        logic                req;
        logic [CLASS_W-1:0]  cls;
        logic [SPEED_W-1:0]  speed;
        logic [DIR_W-1:0]    dir;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic                season;
        logic [BIN_W-1:0]    bin;
    } wx_item_t;

    // one result item
    typedef struct packed {
        status_t             status;
        logic [OUT_W-1:0]    count;
        logic [SHARE_W-1:0]  share;
        logic [OUT_W-1:0]    total;
        logic [OUT_W-1:0]    wind_total;
    } cell_report_t;

    // address of a cell that has been counted into
    typedef struct packed {
        logic                season;
        logic [DIR_W-1:0]    dir;
        logic [CLASS_W-1:0]  cls;
        logic [BIN_W-1:0]    bin;
    } cell_addr_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    cfg_reg_t               cfg_index = REG_WARM_START_MONTH;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   req_type = REQ_ADD;
    logic [CLASS_W-1:0]     stability_class = '0;
    logic signed [SPEED_W-1:0] wind_speed = '0;
    logic [DIR_W-1:0]       wind_dir = '0;
    logic [MONTH_W-1:0]     obs_month = '0;
    logic [DAY_W-1:0]       obs_day = '0;
    logic                   read_season = SEASON_COLD;
    logic [BIN_W-1:0]       read_speed_bin = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [OUT_W-1:0]       cell_count;
    logic [SHARE_W-1:0]     cell_share;
    logic [OUT_W-1:0]       season_total;
    logic [OUT_W-1:0]       season_wind_total;

    // predictor state
    logic [COUNT_BITS-1:0]  hist_cells [2][DIRECTIONS][CLASSES][SPEED_BINS];
    logic [COUNT_BITS-1:0]  hist_season_totals [2];
    logic [COUNT_BITS-1:0]  hist_wind_totals [2];
    logic [MONTH_W-1:0]     win_start_month = RST_START_MONTH;
    logic [DAY_W-1:0]       win_start_day   = RST_START_DAY;
    logic [MONTH_W-1:0]     win_end_month   = RST_END_MONTH;
    logic [DAY_W-1:0]       win_end_day     = RST_END_DAY;

    cell_report_t           expected_reports [$];
    cell_addr_t             touched_cells [$];

    int send_idle_pct = 11;
    int stall_pct     = 59;
    int error_count   = 0;
    int n_checked     = 0;
    int n_adds        = 0;
    int n_reads       = 0;
    int n_rejected    = 0;
    int n_windows     = 0;

    wind_class_joint_histogram #(
        .DIRECTIONS (DIRECTIONS),
        .CLASSES    (CLASSES),
        .SPEED_BINS (SPEED_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic warm_date(input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d);
        int key;
        int s;
        int e;
        key = int'(m) * 32 + int'(d);
        s   = int'(win_start_month) * 32 + int'(win_start_day);
        e   = int'(win_end_month) * 32 + int'(win_end_day);
        if (s < e)
            return (key > s) && (key <= e);
        if (s > e)
            return (key > s) || (key <= e);
        return 1'b0;
    endfunction

    // number of thresholds reached, capped at the top bin
    function automatic logic [BIN_W-1:0] speed_class(input logic [SPEED_W-1:0] spd);
        int k;
        k = 0;
        for (int i = 0; i < EDGE_COUNT; i++)
            if (spd >= SPEED_EDGES[i])
                k++;
        if (k > SPEED_BINS - 1)
            k = SPEED_BINS - 1;
        return BIN_W'(k);
    endfunction

    function automatic logic [SHARE_W-1:0] q16_share(input logic [COUNT_BITS-1:0] count,
                                                     input logic [COUNT_BITS-1:0] total);
        longint q;
        if (total == '0)
            return '0;
        q = (longint'(count) << 16) / longint'(total);
        if (q > 65536)
            q = 65536;
        return SHARE_W'(q);
    endfunction

    // Applies one request to the predicted histogram and returns its result
    function automatic cell_report_t histogram_step(input wx_item_t it);
        cell_report_t          r;
        cell_addr_t            a;
        logic                  season;
        logic [DIR_W-1:0]      n;
        logic [BIN_W-1:0]      k;
        logic [COUNT_BITS-1:0] cnt;
        r = '0;
        r.status = ST_OK;
        // calm shares direction index 0 with north
        n = (it.dir == '0) ? '0 : it.dir - 1'b1;
        if (it.req == REQ_READ) begin
            if (it.cls >= CLASSES || it.dir > DIRECTIONS || it.bin >= SPEED_BINS) begin
                r.status = ST_BAD_READ;
                return r;
            end
            season = it.season;
            k      = it.bin;
            cnt    = hist_cells[season][n][it.cls][k];
        end
        else begin
            // first fault wins: class, then sign, then direction
            if (it.cls >= CLASSES)
                r.status = ST_BAD_CLASS;
            else if (it.speed[SPEED_W-1])
                r.status = ST_NEG_SPEED;
            else if (it.dir > DIRECTIONS)
                r.status = ST_BAD_DIR;
            if (r.status != ST_OK)
                return r;
            k      = speed_class(it.speed);
            season = warm_date(it.month, it.day);
            hist_cells[season][n][it.cls][k] = sat_inc(hist_cells[season][n][it.cls][k]);
            hist_season_totals[season] = sat_inc(hist_season_totals[season]);
            if (k != '0)
                hist_wind_totals[season] = sat_inc(hist_wind_totals[season]);
            cnt = hist_cells[season][n][it.cls][k];
            a.season = season;
            a.dir    = it.dir;
            a.cls    = it.cls;
            a.bin    = k;
            touched_cells.push_back(a);
            if (touched_cells.size() > RECENT_CELLS)
                void'(touched_cells.pop_front());
        end
        r.count      = OUT_W'(cnt);
        r.share      = q16_share(cnt, hist_season_totals[season]);
        r.total      = OUT_W'(hist_season_totals[season]);
        r.wind_total = OUT_W'(hist_wind_totals[season]);
        return r;
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic wx_item_t add_obs(input logic [CLASS_W-1:0] cls,
                                         input logic [SPEED_W-1:0] spd,
                                         input logic [DIR_W-1:0] dir,
                                         input logic [MONTH_W-1:0] m,
                                         input logic [DAY_W-1:0] d);
        wx_item_t it;
        it.req    = REQ_ADD;
        it.cls    = cls;
        it.speed  = spd;
        it.dir    = dir;
        it.month  = m;
        it.day    = d;
        // read fields are don't-care for adds
        it.season = 1'($urandom);
        it.bin    = BIN_W'($urandom);
        return it;
    endfunction

    function automatic wx_item_t read_req(input logic season,
                                          input logic [CLASS_W-1:0] cls,
                                          input logic [DIR_W-1:0] dir,
                                          input logic [BIN_W-1:0] bin);
        wx_item_t it;
        it.req    = REQ_READ;
        it.cls    = cls;
        it.dir    = dir;
        it.season = season;
        it.bin    = bin;
        // speed and date are don't-care for reads
        it.speed  = SPEED_W'($urandom);
        it.month  = MONTH_W'($urandom);
        it.day    = DAY_W'($urandom);
        return it;
    endfunction

    function automatic wx_item_t rand_observation();
        logic [CLASS_W-1:0] cls;
        logic [SPEED_W-1:0] spd;
        logic [DIR_W-1:0]   dir;
        logic [MONTH_W-1:0] m;
        logic [DAY_W-1:0]   d;
        int                 pick;
        // classes: mostly a few busy ones so that cells build up counts
        pick = $urandom_range(99);
        if (pick < 4)
            cls = CLASS_W'($urandom_range(CLASSES, CLASS_MAX));
        else if (pick < 50)
            cls = CLASS_W'($urandom_range(0, 1));
        else
            cls = CLASS_W'($urandom_range(0, CLASSES - 1));
        pick = $urandom_range(99);
        if (pick < 4)
            spd = SPEED_W'($urandom_range(32768, 65535));
        else if (pick < 84)
            spd = SPEED_W'($urandom_range(0, 1200));
        else
            spd = SPEED_W'($urandom_range(0, 32767));
        pick = $urandom_range(99);
        if (pick < 4)
            dir = DIR_W'($urandom_range(DIRECTIONS + 1, DIR_MAX));
        else if (pick < 50)
            dir = DIR_W'($urandom_range(0, 3));
        else
            dir = DIR_W'($urandom_range(0, DIRECTIONS));
        // dates: a quarter right at the window edges, a few outside the calendar
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(1)) begin
                m = win_start_month;
                d = win_start_day + DAY_W'($urandom_range(0, 2)) - 1'b1;
            end
            else begin
                m = win_end_month;
                d = win_end_day + DAY_W'($urandom_range(0, 2)) - 1'b1;
            end
        end
        else if (pick < 95) begin
            m = MONTH_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, 31));
        end
        else begin
            m = MONTH_W'($urandom);
            d = DAY_W'($urandom);
        end
        return add_obs(cls, spd, dir, m, d);
    endfunction

    function automatic wx_item_t rand_read();
        cell_addr_t a;
        if (touched_cells.size() != 0 && $urandom_range(99) < 60) begin
            a = touched_cells[$urandom_range(0, touched_cells.size() - 1)];
            return read_req(a.season, a.cls, a.dir, a.bin);
        end
        return read_req(1'($urandom), CLASS_W'($urandom),
                        ($urandom_range(99) < 85) ? DIR_W'($urandom_range(0, DIRECTIONS))
                                                  : DIR_W'($urandom),
                        BIN_W'($urandom));
    endfunction

    // ---------------------------------------------------------------- driving

    // Presents one item and waits for it to be taken; valid stays high on return
    task automatic send_item(input wx_item_t it);
        cell_report_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        req_type        <= it.req;
        stability_class <= it.cls;
        wind_speed      <= it.speed;
        wind_dir        <= it.dir;
        obs_month       <= it.month;
        obs_day         <= it.day;
        read_season     <= it.season;
        read_speed_bin  <= it.bin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = histogram_step(it);
        expected_reports.push_back(want);
        if (it.req == REQ_READ)
            n_reads++;
        else begin
            n_adds++;
            if (want.status != ST_OK)
                n_rejected++;
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_WARM_START_MONTH: win_start_month = MONTH_W'(val);
            REG_WARM_START_DAY:   win_start_day   = DAY_W'(val);
            REG_WARM_END_MONTH:   win_end_month   = MONTH_W'(val);
            REG_WARM_END_DAY:     win_end_day     = DAY_W'(val);
            default: ;
        endcase
    endtask

    // Only called with nothing in flight
    task automatic write_window(input logic [MONTH_W-1:0] sm, input logic [DAY_W-1:0] sd,
                                input logic [MONTH_W-1:0] em, input logic [DAY_W-1:0] ed);
        write_reg(REG_WARM_START_MONTH, CFG_W'(sm));
        write_reg(REG_WARM_START_DAY,   CFG_W'(sd));
        write_reg(REG_WARM_END_MONTH,   CFG_W'(em));
        write_reg(REG_WARM_END_DAY,     CFG_W'(ed));
        cfg_wr_en <= 1'b0;
        n_windows++;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s = %0d, expected %0d",
                                   n_checked, name, got, want));
    endtask

    // Result side: check each taken item, then choose next cycle's stall
    always @(posedge clk) begin
        cell_report_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0)
                report_error($sformatf("result with status %0d and no request waiting",
                                       status));
            else begin
                want = expected_reports.pop_front();
                compare_field("status",            32'(status),            32'(want.status));
                compare_field("cell_count",        32'(cell_count),        32'(want.count));
                compare_field("cell_share",        32'(cell_share),        32'(want.share));
                compare_field("season_total",      32'(season_total),      32'(want.total));
                compare_field("season_wind_total", 32'(season_wind_total), 32'(want.wind_total));
            end
            n_checked++;
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: ends the run after a long stretch with no handshake
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    // Reads of a freshly cleared store: zero counts and zero share
    task automatic test_empty_cells();
        send_item(read_req(SEASON_COLD, '0, '0, '0));
        send_item(read_req(SEASON_WARM, CLASS_W'(CLASSES - 1), DIR_W'(DIRECTIONS),
                           BIN_W'(SPEED_BINS - 1)));
    endtask

    // Speeds either side of the thresholds, calm folded onto north, top bin cap
    task automatic test_speed_classes();
        send_item(add_obs('0, 16'd0,     '0,                 4'd7, 5'd1));
        send_item(add_obs('0, 16'd74,    DIR_W'(1),          4'd7, 5'd1));
        send_item(add_obs(3'd1, 16'd75,  DIR_W'(2),          4'd7, 5'd1));
        send_item(add_obs(3'd1, 16'd999, DIR_W'(3),          4'd7, 5'd1));
        send_item(add_obs(CLASS_W'(CLASSES - 1), 16'd1000,  DIR_W'(DIRECTIONS), 4'd7, 5'd1));
        send_item(add_obs(CLASS_W'(CLASSES - 1), 16'd32767, DIR_W'(DIRECTIONS), 4'd7, 5'd1));
    endtask

    // Dates on both sides of the default window edges and the year ends
    task automatic test_season_window_edges();
        send_item(add_obs(3'd2, 16'd100, DIR_W'(5), 4'd4,  5'd15));
        send_item(add_obs(3'd2, 16'd100, DIR_W'(5), 4'd4,  5'd16));
        send_item(add_obs(3'd2, 16'd100, DIR_W'(5), 4'd10, 5'd15));
        send_item(add_obs(3'd2, 16'd100, DIR_W'(5), 4'd10, 5'd16));
        send_item(add_obs(3'd2, 16'd100, DIR_W'(5), 4'd12, 5'd31));
        send_item(add_obs(3'd2, 16'd100, DIR_W'(5), 4'd1,  5'd1));
    endtask

    // Bad observations, including several faults at once to check the priority
    task automatic test_rejected_items();
        send_item(add_obs(CLASS_W'(CLASS_MAX), 16'hFFFF, DIR_W'(DIRECTIONS + 1), 4'd6, 5'd6));
        send_item(add_obs(CLASS_W'(CLASSES - 1), 16'h8000, DIR_W'(DIR_MAX), 4'd6, 5'd6));
        send_item(add_obs('0, 16'd0, DIR_W'(DIRECTIONS + 1), 4'd6, 5'd6));
        send_item(add_obs(3'd3, 16'd500, DIR_W'(DIR_MAX), 4'd6, 5'd6));
    endtask

    // Reads of counted cells and read addresses out of range
    task automatic test_cell_reads();
        send_item(read_req(SEASON_COLD, 3'd2, DIR_W'(5), BIN_W'(1)));
        send_item(read_req(SEASON_WARM, '0, DIR_W'(1), '0));
        send_item(read_req(SEASON_WARM, CLASS_W'(CLASS_MAX), DIR_W'(1), '0));
        send_item(read_req(SEASON_COLD, '0, DIR_W'(DIRECTIONS + 1), '0));
        send_item(read_req(SEASON_WARM, CLASS_W'(CLASS_MAX), DIR_W'(DIR_MAX),
                           BIN_W'(SPEED_BINS - 1)));
    endtask

    // Random mix over several warm windows and the three idling patterns
    task automatic test_random_traffic();
        int per_window;
        per_window = RANDOM_ITEMS / WINDOW_SETUPS;
        for (int w = 0; w < WINDOW_SETUPS; w++) begin
            wait_for_results();
            case (w)
                0: write_window(4'd1, 5'd0, 4'd12, 5'd31);     // widest window
                1: write_window(4'd6, 5'd10, 4'd6, 5'd10);     // equal keys, empty
                2: write_window(4'd12, 5'd31, 4'd1, 5'd0);     // wraps, extreme ends
                3: write_window(MONTH_W'($urandom_range(9, 12)), DAY_W'($urandom),
                                MONTH_W'($urandom_range(1, 4)), DAY_W'($urandom));
                4: write_window(MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom),
                                MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom));
                default: write_window(RST_START_MONTH, RST_START_DAY,
                                      RST_END_MONTH, RST_END_DAY);
            endcase
            if (w < 2) begin
                send_idle_pct = 11;
                stall_pct     = 59;
            end
            else if (w < 4) begin
                send_idle_pct = 59;
                stall_pct     = 11;
            end
            else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            repeat (per_window)
                send_item(($urandom_range(99) < 75) ? rand_observation() : rand_read());
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        foreach (hist_cells[s, n, c, b])
            hist_cells[s][n][c][b] = '0;
        foreach (hist_season_totals[s])
        begin
            hist_season_totals[s] = '0;
            hist_wind_totals[s]   = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_cells();
        test_speed_classes();
        test_season_window_edges();
        test_rejected_items();
        test_cell_reads();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d observations (%0d rejected) and %0d cell reads",
                 n_adds, n_rejected, n_reads);
        $display("over %0d warm window settings; %0d results checked, %0d mismatches",
                 n_windows, n_checked, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ wind_class_joint_histogram.f @@
src/wcjh_pkg.sv
src/wcjh_ram.sv
src/wcjh_div.sv
src/wind_class_joint_histogram.sv
sim/tb_top.sv
